### sv/unix_seconds_to_calendar_defines.svh
// Assertion macros for the Unix time to calendar converter.
`ifndef UNIX_SECONDS_TO_CALENDAR_DEFINES_SVH
`define UNIX_SECONDS_TO_CALENDAR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define USC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define USC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/uscal_pkg.sv
// Package: constants, stage record and month table for the Unix time to calendar converter.
`default_nettype none

package uscal_pkg;

    // Pipeline depth in register stages
    localparam int STAGES = 15;

    // Seconds from 0000-01-01 to 1970-01-01, and the last valid second of 9999
    localparam logic [40:0] SEC_OFFSET = 41'd62167219200;
    localparam logic [40:0] SEC_LAST   = 41'd315569519999;

    localparam logic [16:0] SECS_PER_DAY = 17'd86400;
    localparam logic [17:0] ERA_DAYS     = 18'd146097;
    localparam logic [17:0] ERA_LAST_DAY = 18'd146096;
    // One era up, minus the 60 days from January 1 to March 1
    localparam logic [21:0] MARCH_LIFT   = 22'd146037;
    // 0000-01-01 was a Saturday
    localparam logic [21:0] WEEK_BIAS    = 22'd6;

    // Reciprocals for exact division by constants: q = (x * RCP) >> SH
    localparam int SH_DAY = 42;   // x < 2^32, divide by 675 (after >> 7)
    localparam logic [32:0] RCP_DAY = 33'(((64'd1 << SH_DAY) + 64'd674) / 64'd675);
    localparam int SH_ERA = 40;   // x < 2^22, divide by 146097
    localparam logic [22:0] RCP_ERA = 23'(((64'd1 << SH_ERA) + 64'd146096) / 64'd146097);
    localparam int SH_60S = 23;   // x < 2^17, divide by 60
    localparam logic [17:0] RCP_60S = 18'(((64'd1 << SH_60S) + 64'd59) / 64'd60);
    localparam int SH_60M = 17;   // x < 2^11, divide by 60
    localparam logic [11:0] RCP_60M = 12'(((64'd1 << SH_60M) + 64'd59) / 64'd60);
    localparam int SH_7 = 25;     // x < 2^22, divide by 7
    localparam logic [22:0] RCP_7 = 23'(((64'd1 << SH_7) + 64'd6) / 64'd7);
    localparam int SH_1460 = 29;  // x < 2^18, divide by 1460
    localparam logic [18:0] RCP_1460 = 19'(((64'd1 << SH_1460) + 64'd1459) / 64'd1460);
    localparam int SH_36524 = 34; // x < 2^18, divide by 36524
    localparam logic [18:0] RCP_36524 = 19'(((64'd1 << SH_36524) + 64'd36523) / 64'd36524);
    localparam int SH_365 = 27;   // x < 2^18, divide by 365
    localparam logic [18:0] RCP_365 = 19'(((64'd1 << SH_365) + 64'd364) / 64'd365);
    localparam int SH_100A = 16;  // x < 2^9, divide by 100
    localparam logic [9:0] RCP_100A = 10'(((64'd1 << SH_100A) + 64'd99) / 64'd100);
    localparam int SH_153 = 19;   // x < 2^11, divide by 153
    localparam logic [11:0] RCP_153 = 12'(((64'd1 << SH_153) + 64'd152) / 64'd153);
    localparam int SH_5 = 14;     // x < 2^11, divide by 5
    localparam logic [11:0] RCP_5 = 12'(((64'd1 << SH_5) + 64'd4) / 64'd5);
    localparam int SH_100B = 21;  // x < 2^14, divide by 100
    localparam logic [14:0] RCP_100B = 15'(((64'd1 << SH_100B) + 64'd99) / 64'd100);

    // Everything an item carries down the pipeline
    typedef struct packed {
        logic        err;
        logic [38:0] usec;     // seconds since 0000-01-01
        logic [21:0] days0;    // days since 0000-01-01
        logic [16:0] rem;      // second of day
        logic [21:0] dm;       // March-based day count, lifted one era
        logic [4:0]  era;
        logic [10:0] mm;       // minute of day
        logic [4:0]  hr;
        logic [5:0]  minute;
        logic [5:0]  secs;
        logic [21:0] wsum;     // days0 plus weekday bias
        logic [19:0] q7;
        logic [2:0]  wd;
        logic [17:0] doe;      // day of era
        logic [6:0]  a1460;
        logic [2:0]  b36524;
        logic        c_last;
        logic [17:0] tsum;
        logic [8:0]  yoe;      // year of era
        logic [1:0]  yoe_c;    // yoe / 100
        logic [8:0]  doy;      // day of March-based year
        logic [3:0]  mp;
        logic [8:0]  v5;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [13:0] year;
        logic [6:0]  year_c;   // year / 100
        logic [8:0]  ydays;
    } pipe_t;

    // Days before the first of each month in a common year
    function automatic logic [8:0] month_offset(input logic [3:0] m);
        logic [8:0] r;
        unique case (m)
            4'd1:    r = 9'd0;
            4'd2:    r = 9'd31;
            4'd3:    r = 9'd59;
            4'd4:    r = 9'd90;
            4'd5:    r = 9'd120;
            4'd6:    r = 9'd151;
            4'd7:    r = 9'd181;
            4'd8:    r = 9'd212;
            4'd9:    r = 9'd243;
            4'd10:   r = 9'd273;
            4'd11:   r = 9'd304;
            4'd12:   r = 9'd334;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

### sv/unix_seconds_to_calendar.sv
// Top level: pipelined Unix seconds to calendar date and time converter.
//
// Input channel: unix_time with in_valid / in_stall. A transfer happens on
// a rising clk edge with in_valid high and in_stall low.
// Output channel: calendar fields and range_error with out_valid / out_stall,
// same rule. One result per input, in input order.
// The path holds 15 register stages. Throughput: one item per clock while
// out_stall is low; every stage takes a new item each cycle unless a stall
// holds it, so items may follow back to back.
// Stall: a stage moves whenever it is empty or the stage after it moves, so
// bubbles close up; in_stall rises only when all 15 stages hold items and the
// receiver stalls. Stalled results hold steady.
// Inputs outside 0000-01-01 00:00:00 .. 9999-12-31 23:59:59 give range_error
// high with all other fields zero.
// Reset (rst_n low, asynchronous) empties the pipeline; no clearing pass.
`default_nettype none
`include "unix_seconds_to_calendar_defines.svh"

module unix_seconds_to_calendar (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [38:0] unix_time,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [13:0]             cal_year,
    output logic [3:0]              cal_month,
    output logic [4:0]              cal_day,
    output logic [4:0]              clock_hour,
    output logic [5:0]              clock_minute,
    output logic [5:0]              clock_second,
    output logic [2:0]              weekday,
    output logic [8:0]              year_day,
    output logic                    range_error
);
    import uscal_pkg::*;

    localparam int LAST = STAGES - 1;

    pipe_t              st_reg  [STAGES];
    pipe_t              st_next [STAGES];
    logic [STAGES-1:0]  vld_reg;
    logic [STAGES-1:0]  vld_next;
    logic [STAGES-1:0]  adv;

    // Stage advance: a stage loads when empty or when its successor moves
    always_comb
    begin
        adv[LAST] = !vld_reg[LAST] || !out_stall;
        for (int k = LAST - 1; k >= 0; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
        vld_next[0] = in_valid;
        for (int k = 1; k < STAGES; k++)
        begin
            vld_next[k] = vld_reg[k-1];
        end
    end

    assign in_stall = !adv[0];

    // Stage logic
    always_comb
    begin
        logic signed [40:0] s_sum;
        logic [64:0] p_day;
        logic [38:0] p_dsec;
        logic [44:0] p_era;
        logic [34:0] p_mm;
        logic [44:0] p_wk;
        logic [21:0] p_doe;
        logic [16:0] p_s;
        logic [22:0] p_hr;
        logic [21:0] p_w7;
        logic [36:0] p_a;
        logic [36:0] p_b;
        logic [10:0] p_min;
        logic [36:0] p_y;
        logic [18:0] p_yq;
        logic [17:0] p_yd;
        logic [10:0] n_mp;
        logic [22:0] p_mp;
        logic [10:0] n_v5;
        logic [22:0] p_v5;
        logic [8:0]  day_w;
        logic [14:0] year_w;
        logic [28:0] p_yc;
        logic [13:0] p_r;
        logic [6:0]  r100;
        logic        leap;
        logic [8:0]  ydays_w;

        // Stage 0: shift origin to year 0 and check range
        st_next[0] = st_reg[0];
        s_sum = 41'(unix_time) + $signed(SEC_OFFSET);
        st_next[0].err  = (s_sum < 0) || (s_sum > $signed(SEC_LAST));
        st_next[0].usec = s_sum[38:0];

        // Stage 1: day count = usec / 86400 as (usec >> 7) / 675
        st_next[1] = st_reg[0];
        p_day = 65'(st_reg[0].usec[38:7]) * 65'(RCP_DAY);
        st_next[1].days0 = p_day[SH_DAY +: 22];

        // Stage 2: second of day, shifted day count, weekday sum
        st_next[2] = st_reg[1];
        p_dsec = 39'(st_reg[1].days0) * 39'(SECS_PER_DAY);
        st_next[2].rem  = 17'(st_reg[1].usec - p_dsec);
        st_next[2].dm   = st_reg[1].days0 + MARCH_LIFT;
        st_next[2].wsum = st_reg[1].days0 + WEEK_BIAS;

        // Stage 3: era, minute of day, week count
        st_next[3] = st_reg[2];
        p_era = 45'(st_reg[2].dm) * 45'(RCP_ERA);
        st_next[3].era = p_era[SH_ERA +: 5];
        p_mm = 35'(st_reg[2].rem) * 35'(RCP_60S);
        st_next[3].mm = p_mm[SH_60S +: 11];
        p_wk = 45'(st_reg[2].wsum) * 45'(RCP_7);
        st_next[3].q7 = p_wk[SH_7 +: 20];

        // Stage 4: day of era, seconds, hour, weekday
        st_next[4] = st_reg[3];
        p_doe = 22'(st_reg[3].era) * 22'(ERA_DAYS);
        st_next[4].doe = 18'(st_reg[3].dm - p_doe);
        p_s = 17'(st_reg[3].mm) * 17'd60;
        st_next[4].secs = 6'(st_reg[3].rem - p_s);
        p_hr = 23'(st_reg[3].mm) * 23'(RCP_60M);
        st_next[4].hr = p_hr[SH_60M +: 5];
        p_w7 = 22'(st_reg[3].q7) * 22'd7;
        st_next[4].wd = 3'(st_reg[3].wsum - p_w7);

        // Stage 5: leap-cycle corrections, minute of hour
        st_next[5] = st_reg[4];
        p_a = 37'(st_reg[4].doe) * 37'(RCP_1460);
        st_next[5].a1460 = p_a[SH_1460 +: 7];
        p_b = 37'(st_reg[4].doe) * 37'(RCP_36524);
        st_next[5].b36524 = p_b[SH_36524 +: 3];
        st_next[5].c_last = (st_reg[4].doe == ERA_LAST_DAY);
        p_min = 11'(st_reg[4].hr) * 11'd60;
        st_next[5].minute = 6'(st_reg[4].mm - p_min);

        // Stage 6: corrected day count of era
        st_next[6] = st_reg[5];
        st_next[6].tsum = st_reg[5].doe - 18'(st_reg[5].a1460) + 18'(st_reg[5].b36524)
                        - 18'(st_reg[5].c_last);

        // Stage 7: year of era
        st_next[7] = st_reg[6];
        p_y = 37'(st_reg[6].tsum) * 37'(RCP_365);
        st_next[7].yoe = p_y[SH_365 +: 9];

        // Stage 8: century count within era
        st_next[8] = st_reg[7];
        p_yq = 19'(st_reg[7].yoe) * 19'(RCP_100A);
        st_next[8].yoe_c = p_yq[SH_100A +: 2];

        // Stage 9: day of March-based year
        st_next[9] = st_reg[8];
        p_yd = 18'(st_reg[8].yoe) * 18'd365;
        st_next[9].doy = 9'(st_reg[8].doe
                         - (p_yd + 18'(st_reg[8].yoe[8:2]) - 18'(st_reg[8].yoe_c)));

        // Stage 10: March-based month
        st_next[10] = st_reg[9];
        n_mp = 11'(st_reg[9].doy) * 11'd5 + 11'd2;
        p_mp = 23'(n_mp) * 23'(RCP_153);
        st_next[10].mp = p_mp[SH_153 +: 4];

        // Stage 11: days before the month, civil month
        st_next[11] = st_reg[10];
        n_v5 = 11'(st_reg[10].mp) * 11'd153 + 11'd2;
        p_v5 = 23'(n_v5) * 23'(RCP_5);
        st_next[11].v5 = p_v5[SH_5 +: 9];
        st_next[11].month = (st_reg[10].mp < 4'd10) ? st_reg[10].mp + 4'd3
                                                     : st_reg[10].mp - 4'd9;

        // Stage 12: day of month and civil year
        st_next[12] = st_reg[11];
        day_w = st_reg[11].doy - st_reg[11].v5 + 9'd1;
        st_next[12].day = day_w[4:0];
        year_w = 15'(st_reg[11].yoe) + 15'(st_reg[11].era) * 15'd400
               + 15'(st_reg[11].month <= 4'd2) - 15'd400;
        st_next[12].year = year_w[13:0];

        // Stage 13: century of year for the leap test
        st_next[13] = st_reg[12];
        p_yc = 29'(st_reg[12].year) * 29'(RCP_100B);
        st_next[13].year_c = p_yc[SH_100B +: 7];

        // Stage 14: leap test, day of year, zero fields on range error
        st_next[LAST] = st_reg[13];
        p_r  = 14'(st_reg[13].year_c) * 14'd100;
        r100 = 7'(st_reg[13].year - p_r);
        leap = (st_reg[13].year[1:0] == 2'd0)
            && ((r100 != 7'd0) || (st_reg[13].year_c[1:0] == 2'd0));
        ydays_w = month_offset(st_reg[13].month) + 9'(st_reg[13].day) - 9'd1
                + 9'((st_reg[13].month > 4'd2) && leap);
        st_next[LAST].ydays = ydays_w;
        if (st_reg[13].err)
        begin
            st_next[LAST].year   = '0;
            st_next[LAST].month  = '0;
            st_next[LAST].day    = '0;
            st_next[LAST].hr     = '0;
            st_next[LAST].minute = '0;
            st_next[LAST].secs   = '0;
            st_next[LAST].wd     = '0;
            st_next[LAST].ydays  = '0;
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < STAGES; k++)
            begin
                if (adv[k])
                begin
                    vld_reg[k] <= vld_next[k];
                end
            end
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < STAGES; k++)
        begin
            if (adv[k])
            begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    // Outputs
    assign out_valid    = vld_reg[LAST];
    assign cal_year     = st_reg[LAST].year;
    assign cal_month    = st_reg[LAST].month;
    assign cal_day      = st_reg[LAST].day;
    assign clock_hour   = st_reg[LAST].hr;
    assign clock_minute = st_reg[LAST].minute;
    assign clock_second = st_reg[LAST].secs;
    assign weekday      = st_reg[LAST].wd;
    assign year_day     = st_reg[LAST].ydays;
    assign range_error  = st_reg[LAST].err;

    // Check terms
    logic err_fields_zero;
    logic ok_fields;
    logic pipe_full;

    assign err_fields_zero = (cal_month == 4'd0) && (cal_day == 5'd0) && (cal_year == 14'd0)
                           && (year_day == 9'd0);
    assign ok_fields = (cal_month >= 4'd1) && (cal_month <= 4'd12) && (cal_day >= 5'd1)
                     && (clock_hour <= 5'd23) && (weekday <= 3'd6) && (year_day <= 9'd365);
    assign pipe_full = out_valid && out_stall && (vld_reg == '1);

    // Checks
    `USC_ASSERT_NOW(a_err_zero, out_valid && range_error, err_fields_zero, "error not zeroed")
    `USC_ASSERT_NOW(a_fields_ok, out_valid && !range_error, ok_fields, "field out of range")
    `USC_ASSERT_NOW(a_full_stall, in_stall, pipe_full, "input stalled while pipeline can move")
    `USC_ASSERT_NEXT(a_drain, out_valid && !out_stall && !vld_reg[LAST-1], !out_valid, "repeat")

endmodule

`default_nettype wire

### verif/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for the Unix seconds to calendar pipeline.
module testbench;
    import uscal_pkg::*;

    // Valid input span: 0000-01-01 00:00:00 .. 9999-12-31 23:59:59
    localparam longint FIRST_SEC = -64'sd62167219200;
    localparam longint LAST_SEC  = 64'sd253402300799;
    localparam longint SPAN_SECS = 64'sd315569520000;
    localparam longint SPAN_DAYS = 64'sd3652425;
    localparam longint DAY_SECS  = 64'sd86400;

    localparam int RANDOM_STAMPS = 1830;
    localparam int QUIET_FROM    = 700;
    localparam int QUIET_TO      = 1100;
    localparam int DRAIN_A       = 24;
    localparam int DRAIN_B       = 1300;

    // Expected calendar fields for one timestamp
    typedef struct {
        longint      stamp;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [2:0]  wday;
        logic [8:0]  yday;
        logic        err;
    } calendar_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic signed [38:0]      unix_time = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [13:0]             cal_year;
    logic [3:0]              cal_month;
    logic [4:0]              cal_day;
    logic [4:0]              clock_hour;
    logic [5:0]              clock_minute;
    logic [5:0]              clock_second;
    logic [2:0]              weekday;
    logic [8:0]              year_day;
    logic                    range_error;

    logic signed [38:0] stamp_queue [$];
    calendar_t          calendar_due [$];
    int                 stamps_offered = 0;
    int                 results_seen = 0;
    int                 fail_count = 0;
    logic               in_taken = 1'b0;

    // Days before the first of each month, common year
    int days_before [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

    unix_seconds_to_calendar uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .unix_time    (unix_time),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .cal_year     (cal_year),
        .cal_month    (cal_month),
        .cal_day      (cal_day),
        .clock_hour   (clock_hour),
        .clock_minute (clock_minute),
        .clock_second (clock_second),
        .weekday      (weekday),
        .year_day     (year_day),
        .range_error  (range_error)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Civil date and time of day for a signed Unix timestamp
    function automatic calendar_t calendar_of(input longint stamp);
        calendar_t c;
        longint    u, days0, rem, dm, era, doe, yoe, doy, mp, day, month, year, yd;
        c = '{default: 0};
        c.stamp = stamp;
        u = stamp - FIRST_SEC;
        if (u < 0 || u > LAST_SEC - FIRST_SEC)
        begin
            c.err = 1'b1;
            return c;
        end
        days0 = u / DAY_SECS;
        rem   = u % DAY_SECS;
        // March-based day count, lifted one era so it never goes negative
        dm    = days0 + 146097 - 60;
        era   = dm / 146097;
        doe   = dm % 146097;
        yoe   = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
        doy   = doe - (365 * yoe + yoe / 4 - yoe / 100);
        mp    = (5 * doy + 2) / 153;
        day   = doy - (153 * mp + 2) / 5 + 1;
        month = (mp < 10) ? mp + 3 : mp - 9;
        year  = yoe + era * 400 + ((month <= 2) ? 1 : 0) - 400;
        yd    = days_before[month - 1] + day - 1;
        if (month > 2 && ((year % 4 == 0 && year % 100 != 0) || year % 400 == 0))
            yd++;
        c.year   = 14'(year);
        c.month  = 4'(month);
        c.day    = 5'(day);
        c.hour   = 5'(rem / 3600);
        c.minute = 6'((rem % 3600) / 60);
        c.second = 6'(rem % 60);
        // 0000-01-01 fell on a Saturday
        c.wday   = 3'((days0 + 6) % 7);
        c.yday   = 9'(yd);
        return c;
    endfunction

    function automatic longint span_pick(input longint n);
        logic [63:0] r;
        r = {$urandom, $urandom};
        return longint'(r % 64'(n));
    endfunction

    task automatic report_mismatch(input string what, input longint got,
                                   input longint want, input longint stamp);
        $display("%0t: %s mismatch, got %0d want %0d (seconds %0d)",
                 $time, what, got, want, stamp);
        fail_count++;
    endtask

    // Sender: offers the next timestamp once the previous transfer is done
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_taken))
        begin
            if (stamp_queue.size() != 0
                && !((stamps_offered == DRAIN_A || stamps_offered == DRAIN_B)
                     && calendar_due.size() != 0)
                && !($urandom_range(99) < 6
                     && !(stamps_offered >= QUIET_FROM && stamps_offered < QUIET_TO)))
            begin
                in_valid  <= 1'b1;
                unix_time <= stamp_queue.pop_front();
                stamps_offered++;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver back-pressure
    always @(negedge clk)
    begin
        if (rst_n)
            out_stall <= ($urandom_range(99) < 6)
                         && !(results_seen >= QUIET_FROM && results_seen < QUIET_TO);
    end

    // Monitor: record accepted inputs, check each result against the oldest one
    always @(posedge clk)
    begin
        calendar_t want;
        if (rst_n)
        begin
            in_taken = in_valid && !in_stall;
            if (in_taken)
                calendar_due.push_back(calendar_of(longint'(unix_time)));
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (calendar_due.size() == 0)
                    report_mismatch("unexpected result", longint'(cal_year), 0, 0);
                else
                begin
                    want = calendar_due.pop_front();
                    if (cal_year !== want.year)
                        report_mismatch("cal_year", longint'(cal_year),
                                        longint'(want.year), want.stamp);
                    if (cal_month !== want.month)
                        report_mismatch("cal_month", longint'(cal_month),
                                        longint'(want.month), want.stamp);
                    if (cal_day !== want.day)
                        report_mismatch("cal_day", longint'(cal_day),
                                        longint'(want.day), want.stamp);
                    if (clock_hour !== want.hour)
                        report_mismatch("clock_hour", longint'(clock_hour),
                                        longint'(want.hour), want.stamp);
                    if (clock_minute !== want.minute)
                        report_mismatch("clock_minute", longint'(clock_minute),
                                        longint'(want.minute), want.stamp);
                    if (clock_second !== want.second)
                        report_mismatch("clock_second", longint'(clock_second),
                                        longint'(want.second), want.stamp);
                    if (weekday !== want.wday)
                        report_mismatch("weekday", longint'(weekday),
                                        longint'(want.wday), want.stamp);
                    if (year_day !== want.yday)
                        report_mismatch("year_day", longint'(year_day),
                                        longint'(want.yday), want.stamp);
                    if (range_error !== want.err)
                        report_mismatch("range_error", longint'(range_error),
                                        longint'(want.err), want.stamp);
                end
            end
        end
    end

    // Stimulus and end of run
    initial
    begin
        logic signed [38:0] raw;
        longint             pick;
        int                 k;
        longint             corner_stamps [$];
        // Range edges, epoch neighborhood, leap rules, year ends
        corner_stamps = '{
            FIRST_SEC, FIRST_SEC - 1, LAST_SEC, LAST_SEC + 1,
            -64'sd274877906944, 64'sd274877906943,
            64'sd0, -64'sd1, 64'sd86399, 64'sd86400, -64'sd86400, -64'sd86401,
            64'sd951782400, 64'sd951868800, -64'sd2203891200,
            -64'sd62162121600, -64'sd62162035200, 64'sd978220800,
            64'sd253402214400, 64'sd253370764800,
            64'sd4107542399, 64'sd4107542400,
            64'sd2147483648, -64'sd2147483648
        };
        foreach (corner_stamps[i])
            stamp_queue.push_back(39'(corner_stamps[i]));
        for (k = 0; k < RANDOM_STAMPS; k++)
        begin
            case ($urandom_range(99)) inside
                [0:69]:  pick = FIRST_SEC + span_pick(SPAN_SECS);
                [70:84]: pick = FIRST_SEC + span_pick(SPAN_DAYS) * DAY_SECS
                                + ($urandom_range(1) ? DAY_SECS - 1 : 64'sd0);
                [85:91]: pick = ($urandom_range(1) ? FIRST_SEC : LAST_SEC)
                                + longint'(int'($urandom_range(6)) - 3);
                default:
                begin
                    raw  = 39'({$urandom, $urandom});
                    pick = longint'(raw);
                end
            endcase
            stamp_queue.push_back(39'(pick));
        end

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        while (stamp_queue.size() != 0 || in_valid)
            @(posedge clk);
        while (calendar_due.size() != 0)
            @(posedge clk);
        repeat (STAGES + 10) @(posedge clk);

        if (fail_count == 0 && calendar_due.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

### sim.f
+incdir+sv
sv/uscal_pkg.sv
sv/unix_seconds_to_calendar.sv
verif/testbench.sv
